// File: hw/rtl/b64_pkg.sv
// Shared types, constants and alphabet lookup functions of the Base64 stream codec.
`timescale 1ns / 1ps

package b64_pkg;

    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_ALPHABET  = 2'd1;
    localparam logic [1:0] REG_PAD_CODE  = 2'd2;

    localparam logic [7:0] PAD_CODE_RESET = 8'd61;

    localparam logic [511:0] ALPHA_STD =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [511:0] ALPHA_ALT =
        "qazwersdfxcvbgtyhnmjklpoiu5647382910+/POIKLMJUYTGHNBVFREWSDCXZAQ";

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic       direction;
        logic       alphabet_select;
        logic [7:0] pad_code;
    } b64_cfg_t;

    // Results of one accepted item: count bytes, bytes[0] goes out first.
    typedef struct packed {
        logic [2:0]      count;
        logic            last;
        logic [3:0][7:0] bytes;
    } b64_cmd_t;

    typedef struct packed {
        logic     valid;
        b64_cmd_t cmd;
    } b64_push_t;

    // Six-bit value to alphabet character.
    function automatic logic [7:0] enc_char(input logic sel, input logic [5:0] idx);
        logic [511:0] tab;
        tab = sel ? ALPHA_ALT : ALPHA_STD;
        return tab[(9'd504 - {idx, 3'b000}) +: 8];
    endfunction

    // Character to six-bit value; characters outside the alphabet give zero.
    // The characters of each alphabet are distinct, so the matches are ORed.
    function automatic logic [5:0] dec_value(input logic sel, input logic [7:0] c);
        logic [511:0] tab;
        logic [5:0]   v;
        tab = sel ? ALPHA_ALT : ALPHA_STD;
        v   = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (tab[(511 - 8 * i) -: 8] == c)
            begin
                v = v | 6'(i);
            end
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/b64_stream_if.sv
// Valid/ready stream interfaces for the codec input and output channels.
`timescale 1ns / 1ps

interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/b64_regs.sv
// APB configuration registers of the codec.
`timescale 1ns / 1ps

module b64_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output b64_pkg::b64_cfg_t              cfg,
    output logic                           stream_clear
);
    import b64_pkg::*;

    logic       direction_reg;
    logic       alphabet_select_reg;
    logic [7:0] pad_code_reg;
    logic       wr;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // A write to the direction register restarts the stream state.
    assign stream_clear = wr && (idx == REG_DIRECTION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg       <= 1'b0;
            alphabet_select_reg <= 1'b0;
            pad_code_reg        <= PAD_CODE_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_DIRECTION: direction_reg       <= pwdata[0];
                REG_ALPHABET:  alphabet_select_reg <= pwdata[0];
                REG_PAD_CODE:  pad_code_reg        <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DIRECTION: prdata = {31'd0, direction_reg};
            REG_ALPHABET:  prdata = {31'd0, alphabet_select_reg};
            REG_PAD_CODE:  prdata = {24'd0, pad_code_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.direction       = direction_reg;
    assign cfg.alphabet_select = alphabet_select_reg;
    assign cfg.pad_code        = pad_code_reg;

endmodule

// File: hw/rtl/b64_front.sv
// Front end: accepts input items, tracks group state and forms the result list.
`timescale 1ns / 1ps

module b64_front (
    input  logic               clk,
    input  logic               rst_n,
    b64_in_if.sink             in_ch,
    input  b64_pkg::b64_cfg_t  cfg,
    input  logic               stream_clear,
    input  logic               queue_full,
    output b64_pkg::b64_push_t push
);
    import b64_pkg::*;

    logic [1:0]  group_position_reg, group_position_next;
    logic [17:0] held_bits_reg, held_bits_next;
    logic        third_char_pad_reg, third_char_pad_next;
    logic [23:0] pending_group_reg, pending_group_next;
    logic        pending_valid_reg, pending_valid_next;
    logic [1:0]  pending_pad_count_reg, pending_pad_count_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [7:0]  prev;
    logic [5:0]  v;
    logic        is_pad;
    logic [23:0] grp;
    logic [1:0]  pads;
    b64_cmd_t    cmd;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && !queue_full;
    assign b           = in_ch.in_byte;
    assign last        = in_ch.in_last;
    assign prev        = held_bits_reg[7:0];
    assign is_pad      = (b == cfg.pad_code);
    assign v           = is_pad ? 6'd0 : dec_value(cfg.alphabet_select, b);
    assign grp         = {held_bits_reg, v};

    always_comb
    begin
        group_position_next    = group_position_reg;
        held_bits_next         = held_bits_reg;
        third_char_pad_next    = third_char_pad_reg;
        pending_group_next     = pending_group_reg;
        pending_valid_next     = pending_valid_reg;
        pending_pad_count_next = pending_pad_count_reg;
        cmd                    = '0;
        pads                   = 2'd0;

        if (!cfg.direction)
        begin
            case (group_position_reg)
                2'd0:
                begin
                    cmd.bytes[0] = enc_char(cfg.alphabet_select, b[7:2]);
                    if (last)
                    begin
                        cmd.bytes[1] = enc_char(cfg.alphabet_select, {b[1:0], 4'b0000});
                        cmd.bytes[2] = cfg.pad_code;
                        cmd.bytes[3] = cfg.pad_code;
                        cmd.count    = 3'd4;
                        cmd.last     = 1'b1;
                        group_position_next = 2'd0;
                    end
                    else
                    begin
                        cmd.count           = 3'd1;
                        held_bits_next      = {10'd0, b};
                        group_position_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    cmd.bytes[0] = enc_char(cfg.alphabet_select, {prev[1:0], b[7:4]});
                    if (last)
                    begin
                        cmd.bytes[1] = enc_char(cfg.alphabet_select, {b[3:0], 2'b00});
                        cmd.bytes[2] = cfg.pad_code;
                        cmd.count    = 3'd3;
                        cmd.last     = 1'b1;
                        group_position_next = 2'd0;
                    end
                    else
                    begin
                        cmd.count           = 3'd1;
                        held_bits_next      = {10'd0, b};
                        group_position_next = 2'd2;
                    end
                end
                default:
                begin
                    cmd.bytes[0] = enc_char(cfg.alphabet_select, {prev[3:0], b[7:6]});
                    cmd.bytes[1] = enc_char(cfg.alphabet_select, b[5:0]);
                    cmd.count    = 3'd2;
                    cmd.last     = last;
                    group_position_next = 2'd0;
                end
            endcase
        end
        else if (pending_valid_reg && last && (group_position_reg != 2'd3))
        begin
            // The held group turns out to be the last complete one.
            cmd.bytes[0] = pending_group_reg[23:16];
            cmd.bytes[1] = pending_group_reg[15:8];
            cmd.bytes[2] = pending_group_reg[7:0];
            cmd.count    = (pending_pad_count_reg == 2'd3) ? 3'd1
                         : 3'd3 - {1'b0, pending_pad_count_reg};
            cmd.last     = 1'b1;
            group_position_next    = 2'd0;
            held_bits_next         = '0;
            third_char_pad_next    = 1'b0;
            pending_group_next     = '0;
            pending_valid_next     = 1'b0;
            pending_pad_count_next = 2'd0;
        end
        else
        begin
            // A third character without the end mark means another group will
            // complete, so the held group goes out whole.
            if (pending_valid_reg && group_position_reg[1])
            begin
                cmd.bytes[0] = pending_group_reg[23:16];
                cmd.bytes[1] = pending_group_reg[15:8];
                cmd.bytes[2] = pending_group_reg[7:0];
                cmd.count    = 3'd3;
                pending_group_next     = '0;
                pending_valid_next     = 1'b0;
                pending_pad_count_next = 2'd0;
            end
            if (group_position_reg != 2'd3)
            begin
                if (last)
                begin
                    group_position_next    = 2'd0;
                    held_bits_next         = '0;
                    third_char_pad_next    = 1'b0;
                    pending_group_next     = '0;
                    pending_valid_next     = 1'b0;
                    pending_pad_count_next = 2'd0;
                end
                else
                begin
                    if (group_position_reg == 2'd0)
                    begin
                        third_char_pad_next = 1'b0;
                    end
                    if (group_position_reg == 2'd2)
                    begin
                        third_char_pad_next = is_pad;
                    end
                    held_bits_next      = {held_bits_reg[11:0], v};
                    group_position_next = group_position_reg + 2'd1;
                end
            end
            else
            begin
                pads = is_pad ? (third_char_pad_reg ? 2'd2 : 2'd1) : 2'd0;
                group_position_next = 2'd0;
                held_bits_next      = '0;
                third_char_pad_next = 1'b0;
                if (last)
                begin
                    cmd.bytes[0] = grp[23:16];
                    cmd.bytes[1] = grp[15:8];
                    cmd.bytes[2] = grp[7:0];
                    cmd.count    = 3'd3 - {1'b0, pads};
                    cmd.last     = 1'b1;
                    pending_group_next     = '0;
                    pending_valid_next     = 1'b0;
                    pending_pad_count_next = 2'd0;
                end
                else
                begin
                    pending_group_next     = grp;
                    pending_pad_count_next = pads;
                    pending_valid_next     = 1'b1;
                end
            end
        end
    end

    assign push.valid = accept && (cmd.count != 3'd0);
    assign push.cmd   = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_position_reg    <= 2'd0;
            held_bits_reg         <= '0;
            third_char_pad_reg    <= 1'b0;
            pending_group_reg     <= '0;
            pending_valid_reg     <= 1'b0;
            pending_pad_count_reg <= 2'd0;
        end
        else if (stream_clear)
        begin
            group_position_reg    <= 2'd0;
            held_bits_reg         <= '0;
            third_char_pad_reg    <= 1'b0;
            pending_group_reg     <= '0;
            pending_valid_reg     <= 1'b0;
            pending_pad_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            group_position_reg    <= group_position_next;
            held_bits_reg         <= held_bits_next;
            third_char_pad_reg    <= third_char_pad_next;
            pending_group_reg     <= pending_group_next;
            pending_valid_reg     <= pending_valid_next;
            pending_pad_count_reg <= pending_pad_count_next;
        end
    end

endmodule

// File: hw/rtl/b64_back.sv
// Back end: two-entry result queue and serializer into the output register.
`timescale 1ns / 1ps

module b64_back (
    input  logic               clk,
    input  logic               rst_n,
    input  b64_pkg::b64_push_t push,
    output logic               queue_full,
    b64_out_if.source          out_ch
);
    import b64_pkg::*;

    b64_cmd_t   fifo_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fifo_cnt_reg, fifo_cnt_next;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    b64_cmd_t   head;
    logic       load;
    logic       at_end;
    logic       pop;

    assign head       = fifo_mem[rd_ptr_reg];
    assign queue_full = (fifo_cnt_reg == 2'd2);
    assign load       = (fifo_cnt_reg != 2'd0) && (!out_valid_reg || out_ch.ready);
    assign at_end     = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop        = load && at_end;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push.valid && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + 2'd1;
        end
        else if (!push.valid && pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            fifo_mem[wr_ptr_reg] <= push.cmd;
        end
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            out_last_reg <= head.last && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            fifo_cnt_reg  <= 2'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
                idx_reg    <= 2'd0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full)
        else $error("push into a full result queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (push.cmd.count != 3'd0) && (push.cmd.count <= 3'd4))
        else $error("pushed result list has a bad count");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_cnt_reg != 2'd0) |-> ({1'b0, idx_reg} < head.count))
        else $error("serializer index beyond the head entry");

    a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("serializer index not restarted after a pop");
`endif

endmodule

// File: hw/rtl/base64_stream_codec.sv
// Top level of the Base64 stream codec: configuration port, front end and back end.
`timescale 1ns / 1ps

// Base64 encoder and decoder over a byte stream with valid/ready channels.
// The input channel carries one byte per transfer with in_last on the final
// byte of a message; the output channel carries one result byte per transfer
// with out_last on the final result of the message. The APB port selects the
// direction (a write restarts the stream), the alphabet and the pad character.
// The front end takes one input transfer per cycle while its two-entry result
// queue has room and turns it into zero to four result bytes. The back end
// sends one result byte per cycle, while the receiver is ready, from the queue
// through an output register, so the results of an item pass through the queue
// and then the output register before they are valid.
// Encoding gives four characters per three input bytes, so the output limits
// its rate; decoding sustains one character per cycle while the queue has room.
// In decode direction a finished group is held until the third character of
// the next group, or the end mark, shows whether it is the last one.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_ch.ready drops; nothing is lost. Reset clears all stream
// state and the queue and restores the register defaults (encode, standard
// alphabet, pad character '=').
module base64_stream_codec (
    input  logic                           clk,
    input  logic                           rst_n,
    b64_in_if.sink                         in_ch,
    b64_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import b64_pkg::*;

    b64_cfg_t  cfg;
    logic      stream_clear;
    logic      queue_full;
    b64_push_t push;

    // Configuration registers and the stream restart on a direction write.
    b64_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cfg          (cfg),
        .stream_clear (stream_clear)
    );

    // Front end: group tracking and result list per accepted byte.
    b64_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .cfg          (cfg),
        .stream_clear (stream_clear),
        .queue_full   (queue_full),
        .push         (push)
    );

    // Back end: queue and one-byte-per-cycle output while the receiver is ready.
    b64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .queue_full (queue_full),
        .out_ch     (out_ch)
    );

endmodule
